// File: rtl/sha256_message_hasher_assert.svh
// Assertion macros for the SHA-256 message hasher checker.
`ifndef SHA256_MESSAGE_HASHER_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_ASSERT_SVH
// Property that must hold on every clock edge outside reset.
`define SHA_ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Property that must hold during and after reset.
`define SHA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);
`endif

// File: rtl/shm_pkg.sv
// Package with the word types, constants and round functions of the SHA-256 hasher.
`default_nettype none
package shm_pkg;
   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  byte_count;
      logic        last;
   } req_word_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_word_type;

   // A command from the front part to the compression engine.
   typedef struct packed {
      logic [15:0][31:0] block;
      logic              final_block;
   } blk_cmd_type;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam int unsigned LEN_LIMIT = 56;

   localparam logic [7:0][31:0] INIT_HASH = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

   localparam logic [63:0][31:0] ROUND_K = {
      32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
      32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
      32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
      32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
      32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
      32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
      32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
      32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
      32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
      32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
      32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
      32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
      32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
      32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
      32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
      32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98};

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned r);
      rotr = (x >> r) | (x << (32 - r));
   endfunction
endpackage
`default_nettype wire

// File: rtl/shm_front.sv
// Front part: packs message words into blocks and builds the padded final blocks.
`default_nettype none
module shm_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire shm_pkg::req_word_type req_word,
   output logic                      cmd_valid,
   input  wire logic                 cmd_ready,
   output shm_pkg::blk_cmd_type      cmd_word
);
   import shm_pkg::*;

   typedef enum logic [1:0] {FR_COLLECT, FR_PAD, FR_LEN} fr_state_type;

   fr_state_type      state_ff, state_in;
   logic [15:0][31:0] block_ff, block_in;
   logic [3:0]        fill_ff, fill_in;
   logic [63:0]       bits_ff, bits_in;
   logic              cvalid_ff, cvalid_in;
   logic              cfinal_ff, cfinal_in;
   logic [2:0]        cnt;
   logic [31:0]       mask, merged;

   // The output register is free when empty or being taken.
   logic slot_free;
   assign slot_free = !cvalid_ff || cmd_ready;
   assign req_ready = slot_free && (state_ff == FR_COLLECT);
   assign cmd_valid = cvalid_ff;
   assign cmd_word  = '{block: block_ff, final_block: cfinal_ff};

   // Merge the valid bytes of the final word with the pad byte.
   always_comb begin
      cnt = (req_word.byte_count > 3'd4) ? 3'd4 : req_word.byte_count;
      case (cnt)
         3'd0:    mask = 32'h0;
         3'd1:    mask = 32'hff000000;
         3'd2:    mask = 32'hffff0000;
         3'd3:    mask = 32'hffffff00;
         default: mask = 32'hffffffff;
      endcase
      merged = (req_word.data_word & mask) | ({24'h0, PAD_BYTE} << (8 * (3 - cnt[1:0])));
   end

   always_comb begin
      state_in  = state_ff;
      block_in  = block_ff;
      fill_in   = fill_ff;
      bits_in   = bits_ff;
      cvalid_in = cvalid_ff && !cmd_ready;
      cfinal_in = cfinal_ff;
      case (state_ff)
         FR_COLLECT: begin
            if (req_valid && req_ready) begin
               if (!req_word.last) begin
                  block_in[fill_ff] = req_word.data_word;
                  bits_in = bits_ff + 64'd32;
                  fill_in = fill_ff + 4'd1;
                  if (fill_ff == 4'd15) begin
                     cvalid_in = 1'b1;
                     cfinal_in = 1'b0;
                  end
               end else begin
                  bits_in = bits_ff + {58'h0, cnt, 3'b000};
                  if (cnt == 3'd4) begin
                     // Full word: the pad byte goes into the next word.
                     block_in[fill_ff] = req_word.data_word;
                     if (fill_ff == 4'd15) begin
                        cvalid_in = 1'b1;
                        cfinal_in = 1'b0;
                        fill_in   = 4'd0;
                        state_in  = FR_PAD;
                     end else begin
                        fill_in  = fill_ff + 4'd1;
                        state_in = FR_PAD;
                     end
                  end else begin
                     block_in[fill_ff] = merged;
                     for (int i = 0; i < 16; i++)
                        if (i > fill_ff) block_in[i] = 32'h0;
                     // A pad in the last word leaves fill at 15.
                     fill_in  = (fill_ff == 4'd15) ? 4'd15 : fill_ff + 4'd1;
                     state_in = FR_LEN;
                  end
               end
            end
         end
         FR_PAD: begin
            if (slot_free) begin
               block_in[fill_ff] = {PAD_BYTE, 24'h0};
               for (int i = 0; i < 16; i++)
                  if (i > fill_ff) block_in[i] = 32'h0;
               fill_in  = (fill_ff == 4'd15) ? 4'd15 : fill_ff + 4'd1;
               state_in = FR_LEN;
            end
         end
         default: begin
            // Words below fill are in use; the length fits only if at most 14 are.
            // A fill of 15 sends the padded block first, and a fill of zero
            // then builds a block of zeros and the length.
            if (slot_free) begin
               cvalid_in = 1'b1;
               if (fill_ff == 4'd15) begin
                  cfinal_in = 1'b0;
                  fill_in   = 4'd0;
               end else if (fill_ff == 4'd0) begin
                  for (int i = 0; i < 14; i++) block_in[i] = 32'h0;
                  block_in[14] = bits_ff[63:32];
                  block_in[15] = bits_ff[31:0];
                  cfinal_in = 1'b1;
                  bits_in   = 64'h0;
                  state_in  = FR_COLLECT;
               end else begin
                  block_in[14] = bits_ff[63:32];
                  block_in[15] = bits_ff[31:0];
                  cfinal_in = 1'b1;
                  fill_in   = 4'd0;
                  bits_in   = 64'h0;
                  state_in  = FR_COLLECT;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      block_ff  <= block_in;
      cfinal_ff <= cfinal_in;
      if (reset) begin
         state_ff  <= FR_COLLECT;
         fill_ff   <= 4'd0;
         bits_ff   <= 64'h0;
         cvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         bits_ff   <= bits_in;
         cvalid_ff <= cvalid_in;
      end
   end
endmodule
`default_nettype wire

// File: rtl/shm_queue.sv
// Two-entry queue of block commands between the front part and the engine.
`default_nettype none
module shm_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire shm_pkg::blk_cmd_type in_word,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output shm_pkg::blk_cmd_type      out_word
);
   import shm_pkg::*;

   blk_cmd_type mem_ff [2];
   logic        wr_ff, rd_ff;
   logic [1:0]  count_ff;
   logic        push, pop;

   assign in_ready  = count_ff != 2'd2;
   assign out_valid = count_ff != 2'd0;
   assign out_word  = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_word;
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule
`default_nettype wire

// File: rtl/shm_engine.sv
// Back part: 64-round compression, one round a cycle, and digest word output.
`default_nettype none
module shm_engine (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 cmd_valid,
   output logic                      cmd_ready,
   input  wire shm_pkg::blk_cmd_type cmd_word,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output shm_pkg::rsp_word_type     rsp_word
);
   import shm_pkg::*;

   typedef enum logic [1:0] {EN_IDLE, EN_ROUND, EN_ADD, EN_EMIT} en_state_type;

   en_state_type      state_ff;
   logic [7:0][31:0]  hash_ff;
   logic [7:0][31:0]  work_ff;
   logic [15:0][31:0] sched_ff;
   logic [5:0]        round_ff;
   logic [2:0]        idx_ff;
   logic              final_ff;
   logic              ovalid_ff;
   rsp_word_type      oword_ff;

   logic [31:0] a, e, t1, t2, wt, wnext, s0, s1;

   assign cmd_ready = (state_ff == EN_IDLE);
   assign rsp_valid = ovalid_ff;
   assign rsp_word  = oword_ff;

   // One round and one schedule step.
   always_comb begin
      a  = work_ff[0];
      e  = work_ff[4];
      wt = sched_ff[0];
      t1 = work_ff[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
         + ((e & work_ff[5]) ^ (~e & work_ff[6])) + ROUND_K[round_ff] + wt;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
         + ((a & work_ff[1]) ^ (a & work_ff[2]) ^ (work_ff[1] & work_ff[2]));
      s0 = rotr(sched_ff[1], 7) ^ rotr(sched_ff[1], 18) ^ (sched_ff[1] >> 3);
      s1 = rotr(sched_ff[14], 17) ^ rotr(sched_ff[14], 19) ^ (sched_ff[14] >> 10);
      wnext = sched_ff[0] + s0 + sched_ff[9] + s1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= EN_IDLE;
         hash_ff   <= INIT_HASH;
         ovalid_ff <= 1'b0;
         round_ff  <= 6'd0;
         idx_ff    <= 3'd0;
         final_ff  <= 1'b0;
      end else begin
         case (state_ff)
            EN_IDLE: begin
               if (cmd_valid) begin
                  sched_ff <= cmd_word.block;
                  final_ff <= cmd_word.final_block;
                  work_ff  <= hash_ff;
                  round_ff <= 6'd0;
                  state_ff <= EN_ROUND;
               end
            end
            EN_ROUND: begin
               work_ff  <= {work_ff[6:4], work_ff[3] + t1, work_ff[2:0], t1 + t2};
               sched_ff <= {wnext, sched_ff[15:1]};
               round_ff <= round_ff + 6'd1;
               if (round_ff == 6'd63) state_ff <= EN_ADD;
            end
            EN_ADD: begin
               for (int i = 0; i < 8; i++) hash_ff[i] <= hash_ff[i] + work_ff[i];
               idx_ff   <= 3'd0;
               state_ff <= final_ff ? EN_EMIT : EN_IDLE;
            end
            default: begin
               // Stream the eight digest words, then restore the initial value.
               if (!ovalid_ff || rsp_ready) begin
                  ovalid_ff <= 1'b1;
                  oword_ff  <= '{digest_word: hash_ff[idx_ff], word_index: idx_ff,
                                last_word: idx_ff == 3'd7};
                  idx_ff    <= idx_ff + 3'd1;
                  if (idx_ff == 3'd7) begin
                     hash_ff  <= INIT_HASH;
                     state_ff <= EN_IDLE;
                  end
               end
            end
         endcase
         if (state_ff != EN_EMIT && ovalid_ff && rsp_ready) ovalid_ff <= 1'b0;
      end
   end
endmodule
`default_nettype wire

// File: rtl/sha256_message_hasher.sv
// Top level of the SHA-256 message hasher.
// Words of a message enter on req_, four bytes each except the final word, which is
// marked last and carries 0 to 4 bytes. The front part packs 16 words into a block
// and builds the padding and length blocks; a two-entry queue hands blocks to the
// compression engine, which runs one round a cycle and takes a block only when idle.
// After the final block the engine streams the eight digest words on rsp_,
// word_index 0 first, last_word on the eighth, and then starts the next message
// from the initial hash value.
`default_nettype none
module sha256_message_hasher (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire shm_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output shm_pkg::rsp_word_type      rsp_word
);
   import shm_pkg::*;

   logic        f_valid, f_ready, q_valid, q_ready;
   blk_cmd_type f_word, q_word;

   shm_front u_front (.clock, .reset, .req_valid, .req_ready, .req_word,
      .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd_word(f_word));
   shm_queue u_queue (.clock, .reset, .in_valid(f_valid), .in_ready(f_ready),
      .in_word(f_word), .out_valid(q_valid), .out_ready(q_ready), .out_word(q_word));
   shm_engine u_engine (.clock, .reset, .cmd_valid(q_valid), .cmd_ready(q_ready),
      .cmd_word(q_word), .rsp_valid, .rsp_ready, .rsp_word);
endmodule
`default_nettype wire

// File: rtl/sha256_message_hasher_checker.sv
// Port-level checker for the SHA-256 message hasher, bound to the top level.
`default_nettype none
`include "sha256_message_hasher_assert.svh"
module sha256_message_hasher_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire shm_pkg::rsp_word_type rsp_word
);
   // A stalled digest word holds.
   `SHA_ASSERT_CLK(rsp_hold,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word),
      "rsp word changed while stalled")
   // The last word flag marks index seven only.
   `SHA_ASSERT_CLK(last_idx,
      rsp_valid |-> (rsp_word.last_word == (rsp_word.word_index == 3'd7)),
      "last_word mismatch")
   // Digest words come in order.
   `SHA_ASSERT_CLK(idx_order,
      rsp_valid && rsp_ready && !rsp_word.last_word |=>
         !rsp_valid || rsp_word.word_index == $past(rsp_word.word_index) + 3'd1,
      "digest index out of order")
   // Nothing is shown during reset's aftermath.
   `SHA_ASSERT_ALWAYS(rst_quiet, reset |=> !rsp_valid, "rsp valid after reset")
endmodule
bind sha256_message_hasher sha256_message_hasher_checker u_checker (.*);
`default_nettype wire

// File: tb/sha256_message_hasher_test.sv
// Self-checking testbench for the SHA-256 message hasher, with its own digest predictor.
`default_nettype none
module sha256_message_hasher_test;
   timeunit 1ns;
   timeprecision 1ps;
   import shm_pkg::*;

   // Digest predictor: keeps its own chaining value, partial block and bit count,
   // and holds the digest words still owed by the block.
   class digest_scoreboard;
      logic [31:0] chain [8];
      logic [7:0]  block_bytes [64];
      int unsigned fill;
      logic [63:0] bit_total;
      rsp_word_type digest_queue [$];
      int unsigned fault_count;

      function new();
         fault_count = 0;
         restart();
      endfunction

      function void restart();
         for (int i = 0; i < 8; i++) chain[i] = INIT_HASH[i];
         fill = 0;
         bit_total = '0;
      endfunction

      function logic [31:0] ror(logic [31:0] x, int unsigned r);
         return (x >> r) | (x << (32 - r));
      endfunction

      // One 64-round compression of the current block into the chaining value.
      function void compress();
         logic [31:0] sched [64];
         logic [31:0] v [8];
         logic [31:0] t1, t2, s0, s1;
         for (int i = 0; i < 16; i++)
            sched[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
                        block_bytes[4*i+3]};
         for (int i = 16; i < 64; i++) begin
            s0 = ror(sched[i-15], 7) ^ ror(sched[i-15], 18) ^ (sched[i-15] >> 3);
            s1 = ror(sched[i-2], 17) ^ ror(sched[i-2], 19) ^ (sched[i-2] >> 10);
            sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
         end
         for (int i = 0; i < 8; i++) v[i] = chain[i];
         for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + sched[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
         end
         for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
      endfunction

      // Note an accepted input word and predict any digest it completes.
      function void note_word(req_word_type w);
         int unsigned nbytes;
         rsp_word_type r;
         nbytes = w.last ? ((w.byte_count > 4) ? 4 : w.byte_count) : 4;
         for (int i = 0; i < nbytes; i++) begin
            block_bytes[fill] = w.data_word[31 - 8*i -: 8];
            fill++;
         end
         bit_total = bit_total + 64'(8 * nbytes);
         if (fill == 64) begin
            compress();
            fill = 0;
         end
         if (!w.last) return;
         // Padding: the marker byte, zeros, an extra block if the length does not fit.
         block_bytes[fill] = PAD_BYTE;
         fill++;
         if (fill > LEN_LIMIT) begin
            while (fill < 64) begin block_bytes[fill] = 8'h00; fill++; end
            compress();
            fill = 0;
         end
         while (fill < 56) begin block_bytes[fill] = 8'h00; fill++; end
         for (int i = 0; i < 8; i++) block_bytes[56 + i] = bit_total[63 - 8*i -: 8];
         compress();
         for (int i = 0; i < 8; i++) begin
            r.digest_word = chain[i];
            r.word_index  = 3'(i);
            r.last_word   = (i == 7);
            digest_queue.push_back(r);
         end
         restart();
      endfunction

      // Compare one digest word with the oldest one owed.
      function void check_word(rsp_word_type got);
         rsp_word_type want;
         if (digest_queue.size() == 0) begin
            $display("%0t: unexpected digest word %h, nothing owed", $realtime, got);
            fault_count++;
            return;
         end
         want = digest_queue.pop_front();
         if (got.digest_word !== want.digest_word) begin
            $display("%0t: digest_word expected %h actual %h", $realtime,
                     want.digest_word, got.digest_word);
            fault_count++;
         end
         if (got.word_index !== want.word_index) begin
            $display("%0t: word_index expected %0d actual %0d", $realtime,
                     want.word_index, got.word_index);
            fault_count++;
         end
         if (got.last_word !== want.last_word) begin
            $display("%0t: last_word expected %b actual %b", $realtime,
                     want.last_word, got.last_word);
            fault_count++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   digest_scoreboard sb = new();
   bit stall_free = 1'b0;

   sha256_message_hasher DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Watch both channels at the rising edge.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) sb.note_word(req_word);
      if (!reset && rsp_valid && rsp_ready) sb.check_word(rsp_word);
   end

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned gap_length();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Receiver readiness, with stall-free stretches.
   initial begin
      int unsigned hold;
      @(negedge clock);
      forever begin
         rsp_ready = 1'b1;
         hold = $urandom_range(1, 12);
         repeat (hold) @(negedge clock);
         if (!stall_free && $urandom_range(3) != 0) begin
            rsp_ready = 1'b0;
            hold = gap_length();
            repeat (hold) @(negedge clock);
         end
      end
   end

   // Drive one word and wait until it is taken.
   task automatic send_word(logic [31:0] data, logic [2:0] count, logic is_last);
      int unsigned pause;
      pause = gap_length();
      if (pause != 0) begin
         req_valid = 1'b0;
         repeat (pause) @(negedge clock);
      end
      req_word.data_word  = data;
      req_word.byte_count = count;
      req_word.last       = is_last;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // One message of full words followed by the final word.
   task automatic send_message(int unsigned full_words, logic [2:0] tail_count,
                               bit fill_ones);
      for (int i = 0; i < full_words; i++)
         send_word(fill_ones ? 32'hffffffff : $urandom(), 3'($urandom_range(7)), 1'b0);
      send_word(fill_ones ? 32'hffffffff : $urandom(), tail_count, 1'b1);
   endtask

   // Wait until every owed digest word has come back.
   task automatic drain_digests();
      while (sb.digest_queue.size() != 0) @(negedge clock);
   endtask

   initial begin
      int unsigned words;
      int unsigned roll;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Directed: empty message, all-ones word with an oversized count,
      // short zero message, and exactly 55 bytes pending before padding.
      send_word(32'h00000000, 3'd0, 1'b1);
      send_message(0, 3'd7, 1'b1);
      send_word(32'h00000000, 3'd0, 1'b0);
      send_word(32'h00000000, 3'd4, 1'b0);
      send_word(32'h00000000, 3'd1, 1'b1);
      send_message(13, 3'd3, 1'b0);

      // Random messages; block-boundary lengths are favored.
      stall_free = 1'b1;
      for (int m = 0; m < 17; m++) begin
         if (m == 10) stall_free = 1'b0;
         roll = $urandom_range(9);
         case (roll)
            0: words = 13;
            1: words = 14;
            2: words = 15;
            3: words = $urandom_range(16, 32);
            default: words = $urandom_range(0, 6);
         endcase
         send_message(words, 3'($urandom_range(7)), 1'b0);
         // Let the sender wait until every digest word is back.
         if (m == 14) drain_digests();
      end

      drain_digests();
      repeat (200) @(posedge clock);
      if (sb.fault_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #2ms;
      $display("end of test: mismatches");
      $finish;
   end
endmodule
`default_nettype wire
